// ===== rtl/core/bwt_pkg.sv =====
package bwt_pkg;

    localparam int SEGMENTS    = 24;
    localparam int IDX_W       = $clog2(SEGMENTS + 1);
    localparam int COORD_W     = 16;
    localparam int CTRL_W      = COORD_W + 1;
    localparam int TAN_W       = 15;
    localparam int WEIGHT_W    = 17;
    localparam int PROD_W      = WEIGHT_W + 1 + CTRL_W;
    localparam int ACC_W       = PROD_W + 2;
    localparam int POINT_IDX_W = 5;
    localparam int FRAC_W      = 16;

    localparam longint CUBE    = longint'(SEGMENTS) * SEGMENTS * SEGMENTS;
    localparam longint ONE_Q16 = 64'sd65536;

    localparam logic [TAN_W-1:0] MIN_TAN_RESET = TAN_W'(960);
    localparam logic [ACC_W-1:0] ROUND_BIAS    = ACC_W'(32768);

    typedef logic [WEIGHT_W-1:0] weight_t;
    typedef weight_t [3:0] wset_t;
    typedef wset_t [SEGMENTS:0] wrom_t;

    typedef struct packed {
        logic signed [CTRL_W-1:0]  p0x;
        logic signed [CTRL_W-1:0]  p1x;
        logic signed [CTRL_W-1:0]  p2x;
        logic signed [CTRL_W-1:0]  p3x;
        logic signed [COORD_W-1:0] p0y;
        logic signed [COORD_W-1:0] p3y;
    } curve_t;

    typedef struct packed {
        curve_t            pts;
        logic [IDX_W-1:0]  idx;
        logic              last;
    } seq_beat_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [POINT_IDX_W-1:0]    index;
        logic                      last;
    } point_t;

    // Bernstein weights in unsigned Q1.16, rounded to nearest, one row per point
    function automatic wrom_t build_weights();
        wrom_t  rom;
        longint u;
        longint t;
        for (int i = 0; i <= SEGMENTS; i++)
        begin
            u = longint'(SEGMENTS - i);
            t = longint'(i);
            rom[i][0] = WEIGHT_W'((u * u * u * ONE_Q16 + CUBE / 2) / CUBE);
            rom[i][1] = WEIGHT_W'((3 * u * u * t * ONE_Q16 + CUBE / 2) / CUBE);
            rom[i][2] = WEIGHT_W'((3 * u * t * t * ONE_Q16 + CUBE / 2) / CUBE);
            rom[i][3] = WEIGHT_W'((t * t * t * ONE_Q16 + CUBE / 2) / CUBE);
        end
        return rom;
    endfunction

    localparam wrom_t WEIGHT_ROM = build_weights();

endpackage

// ===== rtl/core/bwt_point_eval.sv =====
module bwt_point_eval (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_vld,
    input  bwt_pkg::seq_beat_t in_beat,
    output logic               adv,
    output logic               out_vld,
    input  logic               out_rdy,
    output bwt_pkg::point_t    out_beat
);

    localparam int Q_W = bwt_pkg::ACC_W - bwt_pkg::FRAC_W;

    // stage W: weights
    logic                     vld_w_reg;
    bwt_pkg::wset_t           w_reg;
    bwt_pkg::curve_t          pts_w_reg;
    logic [bwt_pkg::IDX_W-1:0] idx_w_reg;
    logic                     last_w_reg;

    // stage M: products
    logic                                  vld_m_reg;
    logic signed [bwt_pkg::PROD_W-1:0]     mx_reg [4];
    logic signed [bwt_pkg::PROD_W-1:0]     my_reg [4];
    logic signed [bwt_pkg::PROD_W-1:0]     mx_next [4];
    logic signed [bwt_pkg::PROD_W-1:0]     my_next [4];
    logic signed [bwt_pkg::CTRL_W-1:0]     cx [4];
    logic signed [bwt_pkg::CTRL_W-1:0]     cy [4];
    logic [bwt_pkg::IDX_W-1:0]             idx_m_reg;
    logic                                  last_m_reg;

    // stage S: sums
    logic                                  vld_s_reg;
    logic signed [bwt_pkg::ACC_W-1:0]      acc_x_reg;
    logic signed [bwt_pkg::ACC_W-1:0]      acc_y_reg;
    logic signed [bwt_pkg::ACC_W-1:0]      acc_x_next;
    logic signed [bwt_pkg::ACC_W-1:0]      acc_y_next;
    logic [bwt_pkg::IDX_W-1:0]             idx_s_reg;
    logic                                  last_s_reg;

    // stage O: output
    logic                                  vld_o_reg;
    bwt_pkg::point_t                       out_reg;
    bwt_pkg::point_t                       out_next;

    function automatic logic signed [bwt_pkg::COORD_W-1:0] sat16(
        input logic signed [Q_W-1:0] q
    );
        logic [Q_W-bwt_pkg::COORD_W:0] hi;
        hi = q[Q_W-1:bwt_pkg::COORD_W-1];
        if ((&hi) || (~|hi))
            return q[bwt_pkg::COORD_W-1:0];
        else if (q[Q_W-1])
            return {1'b1, {(bwt_pkg::COORD_W-1){1'b0}}};
        else
            return {1'b0, {(bwt_pkg::COORD_W-1){1'b1}}};
    endfunction

    assign adv      = !vld_o_reg || out_rdy;
    assign out_vld  = vld_o_reg;
    assign out_beat = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_w_reg <= 1'b0;
            vld_m_reg <= 1'b0;
            vld_s_reg <= 1'b0;
            vld_o_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_w_reg <= in_vld;
            vld_m_reg <= vld_w_reg;
            vld_s_reg <= vld_m_reg;
            vld_o_reg <= vld_s_reg;
        end
    end

    always_comb
    begin
        cx[0] = pts_w_reg.p0x;
        cx[1] = pts_w_reg.p1x;
        cx[2] = pts_w_reg.p2x;
        cx[3] = pts_w_reg.p3x;
        cy[0] = bwt_pkg::CTRL_W'(pts_w_reg.p0y);
        cy[1] = bwt_pkg::CTRL_W'(pts_w_reg.p0y);
        cy[2] = bwt_pkg::CTRL_W'(pts_w_reg.p3y);
        cy[3] = bwt_pkg::CTRL_W'(pts_w_reg.p3y);
        for (int k = 0; k < 4; k++)
        begin
            mx_next[k] = $signed({1'b0, w_reg[k]}) * cx[k];
            my_next[k] = $signed({1'b0, w_reg[k]}) * cy[k];
        end
    end

    always_comb
    begin
        acc_x_next = bwt_pkg::ACC_W'(mx_reg[0]) + bwt_pkg::ACC_W'(mx_reg[1])
                   + bwt_pkg::ACC_W'(mx_reg[2]) + bwt_pkg::ACC_W'(mx_reg[3])
                   + $signed(bwt_pkg::ROUND_BIAS);
        acc_y_next = bwt_pkg::ACC_W'(my_reg[0]) + bwt_pkg::ACC_W'(my_reg[1])
                   + bwt_pkg::ACC_W'(my_reg[2]) + bwt_pkg::ACC_W'(my_reg[3])
                   + $signed(bwt_pkg::ROUND_BIAS);
    end

    always_comb
    begin
        out_next.x     = sat16($signed(acc_x_reg[bwt_pkg::ACC_W-1:bwt_pkg::FRAC_W]));
        out_next.y     = sat16($signed(acc_y_reg[bwt_pkg::ACC_W-1:bwt_pkg::FRAC_W]));
        out_next.index = bwt_pkg::POINT_IDX_W'(idx_s_reg);
        out_next.last  = last_s_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w_reg      <= bwt_pkg::WEIGHT_ROM[in_beat.idx];
            pts_w_reg  <= in_beat.pts;
            idx_w_reg  <= in_beat.idx;
            last_w_reg <= in_beat.last;

            for (int k = 0; k < 4; k++)
            begin
                mx_reg[k] <= mx_next[k];
                my_reg[k] <= my_next[k];
            end
            idx_m_reg  <= idx_w_reg;
            last_m_reg <= last_w_reg;

            acc_x_reg  <= acc_x_next;
            acc_y_reg  <= acc_y_next;
            idx_s_reg  <= idx_m_reg;
            last_s_reg <= last_m_reg;

            out_reg    <= out_next;
        end
    end

endmodule

// ===== rtl/core/bezier_wire_tessellator.sv =====
// Channel   Dir  Beat contents (low bit up)                 Handshake
// s_axis    in   start_x, start_y, end_x, end_y             tvalid/tready
// m_axis    out  point_x, point_y, point_index; tlast=last  tvalid/tready
// cfg       in   min_tangent                                cfg_wr_en, no wait
//
// One point per cycle unless the output stalls: a wire gives SEGMENTS+1 = 25
// points from the point sequencer feeding the single evaluator pipeline;
// wires follow without gaps once the next wire is held in the input register.
// Stages: input reg, sequencer, weights, multiply, sum, saturate/output reg.
// Reset is asynchronous, active low; min_tangent returns to 960.
// An output stall freezes the whole point pipeline; the input register still
// takes one wire while a curve is in progress.
module bezier_wire_tessellator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [14:0] cfg_wr_data,     // min_tangent
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,    // start_x, start_y, end_x, end_y
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,    // point_x, point_y, point_index, pad
    output logic        m_axis_tlast
);

    localparam int CW = bwt_pkg::COORD_W;

    logic [bwt_pkg::TAN_W-1:0] min_tan_reg;

    // input register
    logic                         in_vld_reg;
    logic signed [CW-1:0]         in_sx_reg;
    logic signed [CW-1:0]         in_sy_reg;
    logic signed [CW-1:0]         in_ex_reg;
    logic signed [CW-1:0]         in_ey_reg;
    logic [bwt_pkg::TAN_W-1:0]    in_half_reg;
    logic signed [CW:0]           dx;
    logic [CW:0]                  dx_abs;
    logic                         in_take;

    // sequencer
    logic                         busy_reg;
    logic [bwt_pkg::IDX_W-1:0]    idx_reg;
    bwt_pkg::curve_t              cur_reg;
    bwt_pkg::curve_t              cur_next;
    logic [bwt_pkg::TAN_W-1:0]    tan;
    logic                         adv;
    logic                         last_issue;
    logic                         load;
    bwt_pkg::seq_beat_t           seq_beat;
    bwt_pkg::point_t              pt;

    assign dx     = {s_axis_tdata[47], s_axis_tdata[47:32]}
                  - {s_axis_tdata[15], s_axis_tdata[15:0]};
    assign dx_abs = dx[CW] ? (CW + 1)'(-dx) : dx;

    assign last_issue    = busy_reg && (idx_reg == bwt_pkg::IDX_W'(bwt_pkg::SEGMENTS));
    assign load          = adv && in_vld_reg && (!busy_reg || last_issue);
    assign s_axis_tready = !in_vld_reg || load;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        tan          = (in_half_reg > min_tan_reg) ? in_half_reg : min_tan_reg;
        cur_next.p0x = bwt_pkg::CTRL_W'(in_sx_reg);
        cur_next.p1x = bwt_pkg::CTRL_W'(in_sx_reg) + $signed({2'b00, tan});
        cur_next.p2x = bwt_pkg::CTRL_W'(in_ex_reg) - $signed({2'b00, tan});
        cur_next.p3x = bwt_pkg::CTRL_W'(in_ex_reg);
        cur_next.p0y = in_sy_reg;
        cur_next.p3y = in_ey_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_tan_reg <= bwt_pkg::MIN_TAN_RESET;
            in_vld_reg  <= 1'b0;
            busy_reg    <= 1'b0;
            idx_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                min_tan_reg <= cfg_wr_data;

            if (in_take)
                in_vld_reg <= 1'b1;
            else if (load)
                in_vld_reg <= 1'b0;

            if (load)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (adv && busy_reg)
            begin
                if (last_issue)
                    busy_reg <= 1'b0;
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_sx_reg   <= s_axis_tdata[15:0];
            in_sy_reg   <= s_axis_tdata[31:16];
            in_ex_reg   <= s_axis_tdata[47:32];
            in_ey_reg   <= s_axis_tdata[63:48];
            in_half_reg <= dx_abs[CW-1:1];
        end
        if (load)
            cur_reg <= cur_next;
    end

    assign seq_beat.pts  = cur_reg;
    assign seq_beat.idx  = idx_reg;
    assign seq_beat.last = last_issue;

    bwt_point_eval u_eval (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (busy_reg),
        .in_beat  (seq_beat),
        .adv      (adv),
        .out_vld  (m_axis_tvalid),
        .out_rdy  (m_axis_tready),
        .out_beat (pt)
    );

    assign m_axis_tdata = {3'b000, pt.index, pt.y, pt.x};
    assign m_axis_tlast = pt.last;

endmodule

// ===== rtl/core/bwt_checker.sv =====
module bwt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    localparam logic [bwt_pkg::POINT_IDX_W-1:0] LAST_IDX =
        bwt_pkg::POINT_IDX_W'(bwt_pkg::SEGMENTS);

    logic [bwt_pkg::POINT_IDX_W-1:0] exp_idx_reg;
    logic                            seen_in_reg;
    logic [bwt_pkg::POINT_IDX_W-1:0] out_idx;

    assign out_idx = m_axis_tdata[36:32];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_idx_reg <= '0;
            seen_in_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                seen_in_reg <= 1'b1;
            if (m_axis_tvalid && m_axis_tready)
                exp_idx_reg <= m_axis_tlast ? '0 : exp_idx_reg + 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output beat changed under stall");

    a_idx_seq: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> out_idx == exp_idx_reg)
        else $error("point index out of sequence");

    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> out_idx == LAST_IDX)
        else $error("last flag on wrong point");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !seen_in_reg |-> !m_axis_tvalid)
        else $error("output beat before any input beat");

endmodule

bind bezier_wire_tessellator bwt_checker u_bwt_checker (.*);

// ===== tb/sv/tb_bezier_wire_tessellator.sv =====
`timescale 1ns / 100ps

module tb_bezier_wire_tessellator;

    localparam int RAND_WIRES  = 216;
    localparam int TAN_PHASES  = 6;
    localparam int TAIL_CYCLES = 10;
    localparam int ERR_SHOWN   = 150;

    typedef struct packed {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] ex;
        logic signed [15:0] ey;
        logic               ends_known;
        logic signed [15:0] x0;
        logic signed [15:0] y0;
        logic signed [15:0] xn;
        logic signed [15:0] yn;
    } wire_job_t;

    localparam int DIR_ROWS = 15;

    // endpoints are exact, so rows with ends_known carry them typed in
    localparam wire_job_t WIRE_TABLE [DIR_ROWS] = '{
        '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1,
          16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000},
        '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1,
          16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000},
        '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1,
          16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF},
        '{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b1,
          16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF},
        '{16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 1'b1,
          16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000},
        '{16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 1'b1,
          16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000},
        '{16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555, 1'b1,
          16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555},
        '{16'shAAAA, 16'sh5555, 16'sh5555, 16'shAAAA, 1'b1,
          16'shAAAA, 16'sh5555, 16'sh5555, 16'shAAAA},
        // odd distances: half truncates
        '{16'sd0, 16'sd0, 16'sd2001, 16'sd0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{16'sd0, 16'sd0, -16'sd2001, 16'sd100, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        // half distance equal to, then just above, the minimum tangent
        '{16'sd100, -16'sd50, 16'sd2020, 16'sd400, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{16'sd0, 16'sd0, 16'sd1922, 16'sd0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{-16'sd1, -16'sd1, 16'sd1, 16'sd1, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{16'sd32000, 16'sd0, 16'sh7FFF, 16'sh8000, 1'b0,
          16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{16'sd1, 16'sd2, 16'sd3, 16'sd4, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}
    };

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [14:0] cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    bwt_pkg::point_t curve_pts_q [$];
    logic [14:0]     min_tan_set;
    int              err_cnt = 0;
    int              burst_left;
    int              rx_left;
    logic            rx_ready;
    bwt_pkg::point_t got_pt;
    bwt_pkg::point_t want_pt;

    bezier_wire_tessellator u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic longint bern_q16(input longint b);
        longint cube;
        cube = longint'(bwt_pkg::SEGMENTS) * bwt_pkg::SEGMENTS * bwt_pkg::SEGMENTS;
        return (b * 65536 + cube / 2) / cube;
    endfunction

    function automatic logic signed [15:0] round_clip16(input longint acc);
        longint q;
        q = (acc + 32768) >>> 16;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return q[15:0];
    endfunction

    // pushes every point of the curve for one wire
    function automatic void predict_curve(input wire_job_t w);
        longint          dx;
        longint          tan_len;
        longint          u;
        longint          t;
        longint          ax;
        longint          ay;
        longint          px [4];
        longint          py [4];
        longint          wt [4];
        bwt_pkg::point_t pt;
        int              n;
        int              k;
        dx = longint'(w.ex) - longint'(w.sx);
        if (dx < 0)
            dx = -dx;
        tan_len = dx / 2;
        if (tan_len < longint'(min_tan_set))
            tan_len = longint'(min_tan_set);
        px[0] = longint'(w.sx);           py[0] = longint'(w.sy);
        px[1] = longint'(w.sx) + tan_len; py[1] = longint'(w.sy);
        px[2] = longint'(w.ex) - tan_len; py[2] = longint'(w.ey);
        px[3] = longint'(w.ex);           py[3] = longint'(w.ey);
        for (n = 0; n <= bwt_pkg::SEGMENTS; n++)
        begin
            u = longint'(bwt_pkg::SEGMENTS - n);
            t = longint'(n);
            wt[0] = bern_q16(u * u * u);
            wt[1] = bern_q16(3 * u * u * t);
            wt[2] = bern_q16(3 * u * t * t);
            wt[3] = bern_q16(t * t * t);
            ax = 0;
            ay = 0;
            for (k = 0; k < 4; k++)
            begin
                ax += wt[k] * px[k];
                ay += wt[k] * py[k];
            end
            pt.x     = round_clip16(ax);
            pt.y     = round_clip16(ay);
            pt.index = bwt_pkg::POINT_IDX_W'(n);
            pt.last  = (n == bwt_pkg::SEGMENTS);
            if (w.ends_known && n == 0)
            begin
                pt.x = w.x0;
                pt.y = w.y0;
            end
            if (w.ends_known && n == bwt_pkg::SEGMENTS)
            begin
                pt.x = w.xn;
                pt.y = w.yn;
            end
            curve_pts_q.push_back(pt);
        end
    endfunction

    function automatic logic signed [15:0] pick_extreme();
        case ($urandom_range(0, 4))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic wire_job_t rand_wire();
        wire_job_t w;
        int        mode;
        w    = '0;
        mode = $urandom_range(0, 9);
        if (mode < 5)
        begin
            w.sx = 16'($urandom);
            w.sy = 16'($urandom);
            w.ex = 16'($urandom);
            w.ey = 16'($urandom);
        end
        else if (mode < 8)
        begin
            // short wires: tangent mostly set by the minimum
            w.sx = 16'($urandom_range(0, 16000)) - 16'sd8000;
            w.sy = 16'($urandom_range(0, 16000)) - 16'sd8000;
            w.ex = w.sx + 16'($urandom_range(0, 8000)) - 16'sd4000;
            w.ey = w.sy + 16'($urandom_range(0, 8000)) - 16'sd4000;
        end
        else
        begin
            w.sx = pick_extreme();
            w.sy = pick_extreme();
            w.ex = pick_extreme();
            w.ey = pick_extreme();
        end
        return w;
    endfunction

    task automatic send_wire(input wire_job_t w);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 40);
        end
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {w.ey, w.ex, w.sy, w.sx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_curve(w);
        @(negedge clk);
        burst_left--;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (curve_pts_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_min_tangent(input logic [14:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        min_tan_set  = v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // receiver: long ready runs, mostly short stalls, now and then a long one
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rx_ready       = 1'b0;
            rx_left        = 0;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_ready = ~rx_ready;
                if (rx_ready)
                    rx_left = $urandom_range(1, 30);
                else if ($urandom_range(0, 2) == 0)
                    rx_left = $urandom_range(1, 20);
                else
                    rx_left = $urandom_range(1, 3);
            end
            rx_left--;
            m_axis_tready <= rx_ready;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_pt.x     = m_axis_tdata[15:0];
            got_pt.y     = m_axis_tdata[31:16];
            got_pt.index = m_axis_tdata[36:32];
            got_pt.last  = m_axis_tlast;
            if (curve_pts_q.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= ERR_SHOWN)
                    $error("unexpected point beat: x %0d y %0d index %0d",
                           got_pt.x, got_pt.y, got_pt.index);
            end
            else
            begin
                want_pt = curve_pts_q.pop_front();
                if (got_pt.x !== want_pt.x)
                begin
                    err_cnt++;
                    if (err_cnt <= ERR_SHOWN)
                        $error("point_x: expected %0d, got %0d", want_pt.x, got_pt.x);
                end
                if (got_pt.y !== want_pt.y)
                begin
                    err_cnt++;
                    if (err_cnt <= ERR_SHOWN)
                        $error("point_y: expected %0d, got %0d", want_pt.y, got_pt.y);
                end
                if (got_pt.index !== want_pt.index)
                begin
                    err_cnt++;
                    if (err_cnt <= ERR_SHOWN)
                        $error("point_index: expected %0d, got %0d",
                               want_pt.index, got_pt.index);
                end
                if (got_pt.last !== want_pt.last)
                begin
                    err_cnt++;
                    if (err_cnt <= ERR_SHOWN)
                        $error("last: expected %0d, got %0d", want_pt.last, got_pt.last);
                end
            end
        end
    end

    initial
    begin : stim
        int tan_plan [TAN_PHASES];
        int r;
        int p;
        int n;

        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        burst_left    = 0;
        min_tan_set   = bwt_pkg::MIN_TAN_RESET;

        tan_plan[0] = 0;
        tan_plan[1] = 32767;
        tan_plan[2] = 1;
        tan_plan[3] = $urandom_range(0, 32767);
        tan_plan[4] = $urandom_range(0, 4000);
        tan_plan[5] = 960;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < DIR_ROWS; r++)
            send_wire(WIRE_TABLE[r]);

        for (p = 0; p < TAN_PHASES; p++)
        begin
            drain();
            set_min_tangent(15'(tan_plan[p]));
            for (n = 0; n < RAND_WIRES / TAN_PHASES; n++)
                send_wire(rand_wire());
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("tb_bezier_wire_tessellator passed");
        else
            $display("tb_bezier_wire_tessellator failed");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("tb_bezier_wire_tessellator failed");
        $finish;
    end

endmodule

// ===== bezier_wire_tessellator.f =====
rtl/core/bwt_pkg.sv
rtl/core/bwt_point_eval.sv
rtl/core/bezier_wire_tessellator.sv
rtl/core/bwt_checker.sv
tb/sv/tb_bezier_wire_tessellator.sv
